### sv/ldi_pkg.sv
// Shared types and constants for the diagonal interleaver.
package ldi_pkg;

    localparam int CW_W   = 8;
    localparam int SYM_W  = 12;
    localparam int SF_W   = 4;
    localparam int CR_W   = 3;
    localparam int FILL_W = 4;
    localparam int BIT_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [SF_W-1:0] SF_MIN = 4'd7;
    localparam logic [CR_W-1:0] CR_MAX = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_SPREADING_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODING_RATE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_DATA_RATE    = 2'd2;

    typedef enum logic [1:0] {
        ST_COLLECT = 2'b01,
        ST_EMIT    = 2'b10
    } state_t;

    typedef struct packed {
        logic             shift;
        logic             clr;
        logic [BIT_W-1:0] bit_sel;
    } cell_ctl_t;

endpackage

### sv/ldi_cell.sv
// One storage cell of the interleaver ring: holds a codeword and taps one bit of it.
module ldi_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ldi_pkg::cell_ctl_t       ctl,
    input  logic                     wr_en,
    input  logic [ldi_pkg::CW_W-1:0] wr_data,
    input  logic                     wrap,
    input  logic [ldi_pkg::CW_W-1:0] nb_data,
    input  logic [ldi_pkg::CW_W-1:0] head_data,
    output logic [ldi_pkg::CW_W-1:0] word,
    output logic                     tap
);

    logic [ldi_pkg::CW_W-1:0] word_reg;
    logic [ldi_pkg::CW_W-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if (ctl.clr)
        begin
            word_next = '0;
        end
        else if (ctl.shift)
        begin
            word_next = wrap ? head_data : nb_data;
        end
        else if (wr_en)
        begin
            word_next = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;
    assign tap  = word_reg[ctl.bit_sel];

endmodule

### sv/lora_diagonal_interleaver.sv
// Top level of the diagonal interleaver: control sequencer, ring of cells and output register.
//
//  Channel  Direction  Handshake            Payload
//  in       sink       in_valid/in_ready    codeword, frame_end
//  out      source     out_valid/out_ready  symbol, run_last, frame_last
//  cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each accepted codeword is written into the ring of MAX_SPREAD cells.
// A request that closes a block starts an emission phase of 4+cr symbols (8 for the
// first block), one per cycle while the output register is free; the ring rotates by
// one cell per symbol and is cleared on the last one. Input is not taken during
// emission. Reset clears the ring and the fill count and loads the default configuration;
// no clearing pass is needed. A stalled output holds the sequencer in place.
module lora_diagonal_interleaver #(
    parameter int MAX_SPREAD = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ldi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ldi_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ldi_pkg::CW_W-1:0]          codeword,
    input  logic                              frame_end,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ldi_pkg::SYM_W-1:0]         symbol,
    output logic                              run_last,
    output logic                              frame_last
);

    localparam int NCELL = MAX_SPREAD;
    localparam int IDX_W = $clog2(NCELL);
    localparam logic [ldi_pkg::SF_W-1:0] SF_MAX = ldi_pkg::SF_W'(MAX_SPREAD);

    ldi_pkg::state_t state_reg, state_next;

    logic [ldi_pkg::SF_W-1:0]   sf_reg;
    logic [ldi_pkg::CR_W-1:0]   cr_reg;
    logic                       ldr_reg;
    logic [ldi_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic                       first_reg, first_next;

    logic [ldi_pkg::SF_W-1:0]   size_reg, size_next;
    logic                       off_reg, off_next;
    logic                       blk_first_reg, blk_first_next;
    logic                       fend_reg, fend_next;
    logic [ldi_pkg::BIT_W-1:0]  bitpos_reg, bitpos_next;

    logic                       out_valid_reg, out_valid_next;
    logic [ldi_pkg::SYM_W-1:0]  symbol_reg;
    logic                       run_last_reg;
    logic                       frame_last_reg;

    logic [ldi_pkg::SF_W-1:0]   sf_eff;
    logic [ldi_pkg::SF_W-1:0]   size_now;
    logic [ldi_pkg::FILL_W-1:0] fill_inc;
    logic [ldi_pkg::CR_W-1:0]   cr_eff;
    logic                       in_acc;
    logic                       close_blk;
    logic                       step;
    logic                       last_sym;

    ldi_pkg::cell_ctl_t         ctl;
    logic [ldi_pkg::CW_W-1:0]   words [NCELL];
    logic [NCELL-1:0]           taps;
    logic [NCELL-1:0]           masked;
    logic [NCELL+1:0]           wide;
    logic [NCELL-1:0]           sym_core;
    logic                       parity;
    logic [ldi_pkg::SYM_W-1:0]  sym_next;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ldi_pkg::ST_COLLECT);
    assign in_acc    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sf_reg  <= ldi_pkg::SF_MIN;
            cr_reg  <= ldi_pkg::CR_W'(1);
            ldr_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ldi_pkg::CFG_SPREADING_FACTOR: sf_reg  <= cfg_data;
                ldi_pkg::CFG_CODING_RATE:      cr_reg  <= cfg_data[ldi_pkg::CR_W-1:0];
                ldi_pkg::CFG_LOW_DATA_RATE:    ldr_reg <= cfg_data[0];
                default:                       ;
            endcase
        end
    end

    always_comb
    begin
        if (sf_reg < ldi_pkg::SF_MIN)
        begin
            sf_eff = ldi_pkg::SF_MIN;
        end
        else if (sf_reg > SF_MAX)
        begin
            sf_eff = SF_MAX;
        end
        else
        begin
            sf_eff = sf_reg;
        end
        size_now  = (first_reg || ldr_reg) ? sf_eff - ldi_pkg::SF_W'(2) : sf_eff;
        cr_eff    = (cr_reg > ldi_pkg::CR_MAX) ? ldi_pkg::CR_MAX : cr_reg;
        fill_inc  = fill_reg + ldi_pkg::FILL_W'(1);
        close_blk = (fill_inc >= size_now) || frame_end;
    end

    assign step     = (state_reg == ldi_pkg::ST_EMIT) && (!out_valid_reg || out_ready);
    assign last_sym = (bitpos_reg == '0);

    always_comb
    begin
        ctl.shift   = step && !last_sym;
        ctl.clr     = step && last_sym;
        ctl.bit_sel = bitpos_reg;
    end

    genvar m;
    generate
        for (m = 0; m < NCELL; m++)
        begin : g_cell
            localparam int NB = (m + 1) % NCELL;
            logic wr_en;
            logic wrap;

            assign wr_en     = in_acc && (fill_reg[IDX_W-1:0] == IDX_W'(m));
            assign wrap      = (ldi_pkg::SF_W'(m) == size_reg - ldi_pkg::SF_W'(1));
            assign masked[m] = taps[m] && (ldi_pkg::SF_W'(m) < size_reg);

            ldi_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .wr_en     (wr_en),
                .wr_data   (codeword),
                .wrap      (wrap),
                .nb_data   (words[NB]),
                .head_data (words[0]),
                .word      (words[m]),
                .tap       (taps[m])
            );
        end
    endgenerate

    always_comb
    begin
        wide     = {masked, 2'b00};
        sym_core = off_reg ? wide[NCELL-1:0] : masked;
        parity   = ^masked;
        if (blk_first_reg)
        begin
            sym_core[1] = parity;
        end
        sym_next = ldi_pkg::SYM_W'(sym_core);
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        first_next     = first_reg;
        size_next      = size_reg;
        off_next       = off_reg;
        blk_first_next = blk_first_reg;
        fend_next      = fend_reg;
        bitpos_next    = bitpos_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;

        case (state_reg)
            ldi_pkg::ST_COLLECT:
            begin
                if (in_acc)
                begin
                    if (close_blk)
                    begin
                        fill_next      = '0;
                        size_next      = size_now;
                        off_next       = (size_now != sf_eff);
                        blk_first_next = first_reg;
                        fend_next      = frame_end;
                        bitpos_next    = first_reg ? ldi_pkg::BIT_W'(7)
                                                   : ldi_pkg::BIT_W'(3) + cr_eff;
                        state_next     = ldi_pkg::ST_EMIT;
                    end
                    else
                    begin
                        fill_next = fill_inc;
                    end
                end
            end
            ldi_pkg::ST_EMIT:
            begin
                if (step)
                begin
                    out_valid_next = 1'b1;
                    if (last_sym)
                    begin
                        first_next = fend_reg;
                        state_next = ldi_pkg::ST_COLLECT;
                    end
                    else
                    begin
                        bitpos_next = bitpos_reg - ldi_pkg::BIT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ldi_pkg::ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ldi_pkg::ST_COLLECT;
            fill_reg      <= '0;
            first_reg     <= 1'b1;
            size_reg      <= '0;
            off_reg       <= 1'b0;
            blk_first_reg <= 1'b0;
            fend_reg      <= 1'b0;
            bitpos_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            first_reg     <= first_next;
            size_reg      <= size_next;
            off_reg       <= off_next;
            blk_first_reg <= blk_first_next;
            fend_reg      <= fend_next;
            bitpos_reg    <= bitpos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            symbol_reg     <= sym_next;
            run_last_reg   <= last_sym;
            frame_last_reg <= last_sym && fend_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign symbol     = symbol_reg;
    assign run_last   = run_last_reg;
    assign frame_last = frame_last_reg;

endmodule
